// File: rtl/sipq_pkg.sv
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and constants of the sorted-insert priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_W          = 16;
  localparam int CODE_W          = 8;
  localparam int EXPIRY_W        = 16;
  localparam int OCC_W           = 5;

  typedef struct packed {
    logic [TIME_W-1:0]   key;
    logic [CODE_W-1:0]   pickup;
    logic [CODE_W-1:0]   dropoff;
    logic [CODE_W-1:0]   kind;
    logic [EXPIRY_W-1:0] expiry;
  } entry_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t    op;
    entry_t entry;
  } cmd_t;

  localparam logic MODE_INSERT = 1'b0;

endpackage

// File: rtl/sipq_if.sv
// ----------------------------------------------------------------------------
// sipq_if
// Request and response channels of the sorted-insert priority queue.
// ----------------------------------------------------------------------------
interface sipq_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [sipq_pkg::TIME_W-1:0]   entry_time;
  logic [sipq_pkg::CODE_W-1:0]   entry_pickup;
  logic [sipq_pkg::CODE_W-1:0]   entry_dropoff;
  logic [sipq_pkg::CODE_W-1:0]   entry_kind;
  logic [sipq_pkg::EXPIRY_W-1:0] entry_expiry;

  modport source (output valid, mode, entry_time, entry_pickup, entry_dropoff, entry_kind,
                  entry_expiry, input ready);
  modport sink (input valid, mode, entry_time, entry_pickup, entry_dropoff, entry_kind,
                entry_expiry, output ready);
endinterface

interface sipq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          out_valid;
  logic [sipq_pkg::TIME_W-1:0]   out_time;
  logic [sipq_pkg::CODE_W-1:0]   out_pickup;
  logic [sipq_pkg::CODE_W-1:0]   out_dropoff;
  logic [sipq_pkg::CODE_W-1:0]   out_kind;
  logic [sipq_pkg::EXPIRY_W-1:0] out_expiry;
  logic [sipq_pkg::OCC_W-1:0]    occupancy;
  logic                          is_empty;
  logic                          is_full;
  logic                          op_error;

  modport source (output valid, out_valid, out_time, out_pickup, out_dropoff, out_kind,
                  out_expiry, occupancy, is_empty, is_full, op_error, input ready);
  modport sink (input valid, out_valid, out_time, out_pickup, out_dropoff, out_kind,
                out_expiry, occupancy, is_empty, is_full, op_error, output ready);
endinterface

// File: rtl/sipq_front.sv
// ----------------------------------------------------------------------------
// sipq_front
// Accepts requests and classifies them against a running occupancy count.
// ----------------------------------------------------------------------------
module sipq_front #(
  parameter int QUEUE_DEPTH = sipq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  sipq_req_if.sink         req,
  output logic             push,
  output sipq_pkg::cmd_t   cmd,
  input  logic             full
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign req.ready = !full;
  assign push      = req.valid && req.ready;

  always_comb begin
    cmd.entry.key     = req.entry_time;
    cmd.entry.pickup  = req.entry_pickup;
    cmd.entry.dropoff = req.entry_dropoff;
    cmd.entry.kind    = req.entry_kind;
    cmd.entry.expiry  = req.entry_expiry;
    count_next        = count;
    if (req.mode == sipq_pkg::MODE_INSERT) begin
      if (count == CNT_W'(QUEUE_DEPTH)) begin
        cmd.op = sipq_pkg::OP_REJECT;
      end else begin
        cmd.op     = sipq_pkg::OP_INSERT;
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (count == '0) begin
        cmd.op = sipq_pkg::OP_REJECT;
      end else begin
        cmd.op     = sipq_pkg::OP_REMOVE;
        count_next = count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count_next;
    end
  end

endmodule

// File: rtl/sipq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sipq_cmd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module sipq_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sipq_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output sipq_pkg::cmd_t pop_cmd
);

  sipq_pkg::cmd_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;

  assign full    = (fill == 2'd2);
  assign avail   = (fill != 2'd0);
  assign pop_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/sipq_back.sv
// ----------------------------------------------------------------------------
// sipq_back
// Shift-register sorted cells; executes one command per cycle, while rsp
// is not stalled, into the response register.
// ----------------------------------------------------------------------------
module sipq_back #(
  parameter int QUEUE_DEPTH = sipq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  sipq_pkg::cmd_t cmd,
  output logic           pop,
  sipq_rsp_if.source     rsp
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sipq_pkg::entry_t   store [QUEUE_DEPTH];
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [QUEUE_DEPTH-1:0] from_pos;
  logic               fire;

  assign fire = avail && (!rsp.valid || rsp.ready);
  assign pop  = fire;

  // from_pos: cell sits at or after the insert position
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign from_pos[i] = (CNT_W'(i) >= count) || (store[i].key > cmd.entry.key);

    always_ff @(posedge clk) begin
      if (fire) begin
        case (cmd.op)
          sipq_pkg::OP_INSERT: begin
            if (i == 0) begin
              if (from_pos[i]) begin
                store[i] <= cmd.entry;
              end
            end else begin
              if (from_pos[(i == 0) ? 0 : i-1]) begin
                store[i] <= store[(i == 0) ? 0 : i-1];
              end else if (from_pos[i]) begin
                store[i] <= cmd.entry;
              end
            end
          end
          sipq_pkg::OP_REMOVE: begin
            if (i < QUEUE_DEPTH-1) begin
              store[i] <= store[(i < QUEUE_DEPTH-1) ? i+1 : i];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (cmd.op)
      sipq_pkg::OP_INSERT: count_next = count + CNT_W'(1);
      sipq_pkg::OP_REMOVE: count_next = count - CNT_W'(1);
      default:             count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.out_valid   <= (cmd.op == sipq_pkg::OP_REMOVE);
      rsp.op_error    <= (cmd.op == sipq_pkg::OP_REJECT);
      rsp.occupancy   <= sipq_pkg::OCC_W'(count_next);
      rsp.is_empty    <= (count_next == '0);
      rsp.is_full     <= (count_next == CNT_W'(QUEUE_DEPTH));
      if (cmd.op == sipq_pkg::OP_REMOVE) begin
        rsp.out_time    <= store[0].key;
        rsp.out_pickup  <= store[0].pickup;
        rsp.out_dropoff <= store[0].dropoff;
        rsp.out_kind    <= store[0].kind;
        rsp.out_expiry  <= store[0].expiry;
      end else begin
        rsp.out_time    <= '0;
        rsp.out_pickup  <= '0;
        rsp.out_dropoff <= '0;
        rsp.out_kind    <= '0;
        rsp.out_expiry  <= '0;
      end
    end
  end

endmodule

// File: rtl/sorted_insert_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_top
// Bounded time-ordered priority queue, smallest time at the head.
//
// req carries one operation per transfer: mode 0 inserts the entry fields,
// mode 1 removes the head. Equal times leave in arrival order.
// rsp returns exactly one result per request, in request order: the removed
// entry (zero for inserts and errors), occupancy, empty/full flags and
// op_error for an insert when full or a remove when empty (queue unchanged).
// A request is written into the command queue and executed by the back
// into the registered rsp. Throughput is one request per cycle while rsp
// is not stalled: the front classifies against its own count, a two-entry
// command queue feeds the back, and the back updates all QUEUE_DEPTH
// cells together by parallel compare and shift.
// A stalled rsp holds its result; req keeps transferring until the command
// queue is full, then ready drops.
// Synchronous reset empties the queue; cell contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_top #(
  parameter int QUEUE_DEPTH = sipq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sipq_req_if.sink   req,
  sipq_rsp_if.source rsp
);

  logic           push;
  logic           full;
  logic           pop;
  logic           avail;
  sipq_pkg::cmd_t push_cmd;
  sipq_pkg::cmd_t pop_cmd;

  sipq_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .push (push),
    .cmd  (push_cmd),
    .full (full)
  );

  sipq_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .avail    (avail),
    .pop_cmd  (pop_cmd)
  );

  sipq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (avail),
    .cmd   (pop_cmd),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

// File: rtl/sipq_checker.sv
// ----------------------------------------------------------------------------
// sipq_checker
// Port-level checks on the priority queue response channel.
// ----------------------------------------------------------------------------
module sipq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          out_valid,
  input logic [sipq_pkg::TIME_W-1:0]   out_time,
  input logic [sipq_pkg::OCC_W-1:0]    occupancy,
  input logic                          is_empty,
  input logic                          is_full,
  input logic                          op_error
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(out_time) && $stable(occupancy))
    else $error("rsp payload changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> occupancy == '0 && !out_valid || occupancy == '0)
    else $error("empty flag with non-zero occupancy");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && op_error |-> !out_valid && out_time == '0)
    else $error("error result carries an entry");

  a_remove_not_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_valid |-> !op_error && !is_full)
    else $error("remove left the queue full");

endmodule

bind sorted_insert_priority_queue_top sipq_checker u_sipq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .out_valid (rsp.out_valid),
  .out_time  (rsp.out_time),
  .occupancy (rsp.occupancy),
  .is_empty  (rsp.is_empty),
  .is_full   (rsp.is_full),
  .op_error  (rsp.op_error)
);
